/* rtl/ral_pkg.sv */
`timescale 1ns / 1ps
// Shared types, sizes and codes for the resizable array list.
// No dependencies; every file but ral_ram imports this package.
package ral_pkg;

  // Number of entries in the element store.
  localparam int DEPTH     = 16;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Field widths of the request and result channels.
  localparam int OP_W      = 3;
  localparam int IDX_W     = 4;
  localparam int DATA_W    = 32;
  localparam int STAT_W    = 2;
  localparam int OUT_CNT_W = 5;
  localparam int CFG_W     = 5;

  // Common widths used when comparing values of different sizes.
  localparam int CMP_W     = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int CLAMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // Reset values of the capacity register and the initial capacity.
  localparam int CFG_RST   = 4;
  localparam int CAP_RST   = (DEPTH < CFG_RST) ? DEPTH : CFG_RST;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_EDIT   = 3'd2,
    OP_DELETE = 3'd3,
    OP_FIND   = 3'd4,
    OP_READ   = 3'd5,
    OP_CLEAR  = 3'd6
  } ral_op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADIDX = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } ral_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_FINISH
  } ral_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load;
    logic        st_we;
    ral_status_t st_code;
    logic        grow;
    logic        append;
    logic        edit;
    logic        clear;
    logic        walk_start;
    logic        walk_step;
    logic        walk_finish;
    logic        out_load;
  } ral_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    ral_op_t op;
    logic    idx_gt_cnt;
    logic    idx_ge_cnt;
    logic    cnt_zero;
    logic    store_full;
    logic    walk_done;
    logic    out_free;
  } ral_stat_t;

endpackage

/* rtl/ral_req_if.sv */
`timescale 1ns / 1ps
// Request channel: valid/ready handshake with op, index and value.
// Depends on ral_pkg for field widths.
interface ral_req_if import ral_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [IDX_W-1:0]         index;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output op, output index, output value, input ready);
  modport sink   (input valid, input op, input index, input value, output ready);
endinterface

/* rtl/ral_rsp_if.sv */
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with status, lookup data and sizes.
// Depends on ral_pkg for field widths.
interface ral_rsp_if import ral_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic                     found;
  logic signed [DATA_W-1:0] read_value;
  logic [OUT_CNT_W-1:0]     element_count;
  logic [OUT_CNT_W-1:0]     logical_capacity;

  modport source (output valid, output status, output found, output read_value,
                  output element_count, output logical_capacity, input ready);
  modport sink   (input valid, input status, input found, input read_value,
                  input element_count, input logical_capacity, output ready);
endinterface

/* rtl/ral_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ral_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/ral_datapath.sv */
`timescale 1ns / 1ps
// Datapath: request latch, count and capacity, element walker and result register.
// Depends on ral_pkg and ral_ram.
module ral_datapath import ral_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ral_cmd_t                 cmd,
  output ral_stat_t                stat,
  input  logic [OP_W-1:0]          in_op,
  input  logic [IDX_W-1:0]         in_index,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        out_status,
  output logic                     out_found,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [OUT_CNT_W-1:0]     out_element_count,
  output logic [OUT_CNT_W-1:0]     out_logical_capacity
);

  // Latched request.
  ral_op_t            op_r, op_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [DATA_W-1:0]  val_r, val_nxt;

  // List state and configuration.
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   cap_r, cap_nxt;
  logic [CFG_W-1:0]   init_r, init_nxt;

  // Per-request result.
  ral_status_t        status_r, status_nxt;
  logic               found_r, found_nxt;
  logic [DATA_W-1:0]  rdval_r, rdval_nxt;

  // Walker: next source address, pending write address, reads left, data pending.
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]  wptr_r, wptr_nxt;
  logic [CNT_W-1:0]   left_r, left_nxt;
  logic               pend_r, pend_nxt;

  // Result register.
  logic                 ovalid_r, ovalid_nxt;
  ral_status_t          ostat_r, ostat_nxt;
  logic                 ofound_r, ofound_nxt;
  logic [DATA_W-1:0]    ordval_r, ordval_nxt;
  logic [OUT_CNT_W-1:0] ocnt_r, ocnt_nxt;
  logic [OUT_CNT_W-1:0] ocap_r, ocap_nxt;

  // RAM port signals.
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;

  // Derived values.
  logic [CMP_W-1:0]   idx_w, cnt_w;
  logic [CNT_W:0]     cap_dbl;
  logic [CNT_W-1:0]   cap_grown;
  logic [CNT_W-1:0]   cap_init;
  logic [CNT_W-1:0]   cnt_dec;
  logic               walk_up;

  ral_ram #(
    .Width (DATA_W),
    .Depth (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Capacity arithmetic: doubling with saturation, clamped initial value.
  always_comb begin
    cap_dbl = {cap_r, 1'b0};
    if (cap_dbl > (CNT_W + 1)'(DEPTH)) begin
      cap_grown = CNT_W'(DEPTH);
    end else begin
      cap_grown = cap_dbl[CNT_W-1:0];
    end
    if (init_r == '0) begin
      cap_init = CNT_W'(1);
    end else if (CLAMP_W'(init_r) > CLAMP_W'(DEPTH)) begin
      cap_init = CNT_W'(DEPTH);
    end else begin
      cap_init = CNT_W'(init_r);
    end
  end

  assign idx_w   = CMP_W'(idx_r);
  assign cnt_w   = CMP_W'(count_r);
  assign cnt_dec = count_r - CNT_W'(1);
  assign walk_up = (op_r == OP_INSERT);

  // Status to the controller.
  always_comb begin
    stat.op         = op_r;
    stat.idx_gt_cnt = (idx_w > cnt_w);
    stat.idx_ge_cnt = (idx_w >= cnt_w);
    stat.cnt_zero   = (count_r == '0);
    stat.store_full = (count_r == cap_r) && (cap_r == CNT_W'(DEPTH));
    stat.walk_done  = !pend_r && (left_r == '0);
    stat.out_free   = !ovalid_r || out_ready;
  end

  // Next-state logic of the datapath registers.
  always_comb begin
    op_nxt     = op_r;
    idx_nxt    = idx_r;
    val_nxt    = val_r;
    count_nxt  = count_r;
    cap_nxt    = cap_r;
    init_nxt   = init_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    rdval_nxt  = rdval_r;
    ptr_nxt    = ptr_r;
    wptr_nxt   = wptr_r;
    left_nxt   = left_r;
    pend_nxt   = pend_r;
    ovalid_nxt = ovalid_r;
    ostat_nxt  = ostat_r;
    ofound_nxt = ofound_r;
    ordval_nxt = ordval_r;
    ocnt_nxt   = ocnt_r;
    ocap_nxt   = ocap_r;
    ram_we     = 1'b0;
    ram_waddr  = count_r[ADDR_W-1:0];
    ram_wdata  = val_r;
    ram_raddr  = ptr_r[ADDR_W-1:0];

    // Configuration write.
    if (cfg_we) begin
      init_nxt = cfg_wdata;
    end

    // Capture a new request.
    if (cmd.load) begin
      op_nxt     = ral_op_t'(in_op);
      idx_nxt    = in_index;
      val_nxt    = in_value;
      status_nxt = ST_OK;
      found_nxt  = 1'b0;
      rdval_nxt  = '0;
    end

    if (cmd.st_we) begin
      status_nxt = cmd.st_code;
    end

    // Double the capacity when the list is full.
    if (cmd.grow && (count_r == cap_r)) begin
      cap_nxt = cap_grown;
    end

    if (cmd.append) begin
      ram_we    = 1'b1;
      ram_waddr = count_r[ADDR_W-1:0];
      count_nxt = count_r + CNT_W'(1);
    end

    if (cmd.edit) begin
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(idx_r);
    end

    if (cmd.clear) begin
      count_nxt = '0;
      cap_nxt   = cap_init;
    end

    // Set up the walk over the affected entries.
    if (cmd.walk_start) begin
      pend_nxt = 1'b0;
      case (op_r)
        OP_INSERT: begin
          ptr_nxt  = cnt_dec;
          left_nxt = CNT_W'(cnt_w - idx_w);
        end
        OP_DELETE: begin
          ptr_nxt  = CNT_W'(idx_w + CMP_W'(1));
          left_nxt = CNT_W'(cnt_w - idx_w - CMP_W'(1));
        end
        OP_FIND: begin
          ptr_nxt  = '0;
          left_nxt = count_r;
        end
        OP_READ: begin
          ptr_nxt  = CNT_W'(idx_w);
          left_nxt = CNT_W'(1);
        end
        default: begin
          left_nxt = '0;
        end
      endcase
    end

    // One walker step: retire the pending word, issue the next read.
    if (cmd.walk_step) begin
      if (pend_r) begin
        case (op_r)
          OP_INSERT, OP_DELETE: begin
            ram_we    = 1'b1;
            ram_waddr = wptr_r;
            ram_wdata = ram_rdata;
          end
          OP_FIND: begin
            if (ram_rdata == val_r) begin
              found_nxt = 1'b1;
            end
          end
          OP_READ: begin
            rdval_nxt = ram_rdata;
          end
          default: begin
          end
        endcase
      end
      if (left_r != '0) begin
        ram_raddr = ptr_r[ADDR_W-1:0];
        pend_nxt  = 1'b1;
        left_nxt  = left_r - CNT_W'(1);
        if (walk_up) begin
          wptr_nxt = ADDR_W'(ptr_r + CNT_W'(1));
          ptr_nxt  = ptr_r - CNT_W'(1);
        end else begin
          wptr_nxt = ADDR_W'(ptr_r - CNT_W'(1));
          ptr_nxt  = ptr_r + CNT_W'(1);
        end
      end else begin
        pend_nxt = 1'b0;
      end
    end

    // Closing action once the walk has drained.
    if (cmd.walk_finish) begin
      case (op_r)
        OP_INSERT: begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(idx_r);
          ram_wdata = val_r;
          count_nxt = count_r + CNT_W'(1);
        end
        OP_DELETE: begin
          count_nxt = cnt_dec;
          if ((cap_r > CNT_W'(1)) && (cnt_dec <= (cap_r >> 1))) begin
            cap_nxt = cap_r >> 1;
          end
        end
        default: begin
        end
      endcase
    end

    // Result register: load a finished result, drop it once taken.
    if (cmd.out_load) begin
      ovalid_nxt = 1'b1;
      ostat_nxt  = status_r;
      ofound_nxt = found_r;
      ordval_nxt = rdval_r;
      ocnt_nxt   = OUT_CNT_W'(count_r);
      ocap_nxt   = OUT_CNT_W'(cap_r);
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cap_r    <= CNT_W'(CAP_RST);
      init_r   <= CFG_W'(CFG_RST);
      pend_r   <= 1'b0;
      left_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      cap_r    <= cap_nxt;
      init_r   <= init_nxt;
      pend_r   <= pend_nxt;
      left_r   <= left_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    idx_r    <= idx_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    rdval_r  <= rdval_nxt;
    ptr_r    <= ptr_nxt;
    wptr_r   <= wptr_nxt;
    ostat_r  <= ostat_nxt;
    ofound_r <= ofound_nxt;
    ordval_r <= ordval_nxt;
    ocnt_r   <= ocnt_nxt;
    ocap_r   <= ocap_nxt;
  end

  assign out_valid            = ovalid_r;
  assign out_status           = ostat_r;
  assign out_found            = ofound_r;
  assign out_read_value       = ordval_r;
  assign out_element_count    = ocnt_r;
  assign out_logical_capacity = ocap_r;

endmodule

/* rtl/ral_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences one request at a time through decode, walk and result.
// Depends on ral_pkg.
module ral_ctrl import ral_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ral_stat_t stat,
  output ral_cmd_t  cmd
);

  ral_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FINISH;
        unique case (stat.op)
          OP_INSERT: begin
            if (!stat.idx_gt_cnt && !stat.store_full) begin
              state_nxt = S_WALK;
            end
          end
          OP_DELETE: begin
            if (!stat.cnt_zero && !stat.idx_ge_cnt) begin
              state_nxt = S_WALK;
            end
          end
          OP_FIND: begin
            state_nxt = S_WALK;
          end
          OP_READ: begin
            if (!stat.idx_ge_cnt) begin
              state_nxt = S_WALK;
            end
          end
          default: begin
          end
        endcase
      end
      S_WALK: begin
        if (stat.walk_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output logic: request handshake and datapath commands.
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.st_code = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        unique case (stat.op)
          OP_APPEND: begin
            if (stat.store_full) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_FULL;
            end else begin
              cmd.grow   = 1'b1;
              cmd.append = 1'b1;
            end
          end
          OP_INSERT: begin
            if (stat.idx_gt_cnt) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_BADIDX;
            end else if (stat.store_full) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_FULL;
            end else begin
              cmd.grow       = 1'b1;
              cmd.walk_start = 1'b1;
            end
          end
          OP_EDIT: begin
            if (stat.idx_ge_cnt) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_BADIDX;
            end else begin
              cmd.edit = 1'b1;
            end
          end
          OP_DELETE: begin
            if (stat.cnt_zero) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_EMPTY;
            end else if (stat.idx_ge_cnt) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_BADIDX;
            end else begin
              cmd.walk_start = 1'b1;
            end
          end
          OP_FIND: begin
            cmd.walk_start = 1'b1;
          end
          OP_READ: begin
            if (stat.idx_ge_cnt) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_BADIDX;
            end else begin
              cmd.walk_start = 1'b1;
            end
          end
          OP_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_WALK: begin
        cmd.walk_step   = 1'b1;
        cmd.walk_finish = stat.walk_done;
      end
      S_FINISH: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/resizable_array_list.sv */
`timescale 1ns / 1ps
// Top level of the resizable array list: controller, datapath and channel wiring.
// Depends on ral_pkg, ral_req_if, ral_rsp_if, ral_ctrl and ral_datapath.
//
// The block keeps an ordered list of signed 32-bit words in a DEPTH-entry RAM
// and handles one request at a time. Append, edit, clear, the unused code and
// every refused request go from decode straight to the result state. Insert,
// delete, find and read first walk over the n entries moved or scanned (for
// insert count - index, for delete count - index - 1, for find count, for
// read one). The walk reads and writes the element RAM through its single
// read and single write port, one entry per cycle. The result state loads
// the result into an output register once that register is free. A finished
// result waits in the output register, and the next request is accepted while
// it is still waiting; a second result then stalls until the first is taken.
// The initial capacity register, which clear loads into the capacity, must be
// written by the user with cfg_we only while no request is in progress; the
// block itself does not enforce this.
module resizable_array_list import ral_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  ral_req_if.sink          in_ch,
  ral_rsp_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  ral_cmd_t  cmd;
  ral_stat_t stat;

  // Sequencing of each request.
  ral_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage, arithmetic and the result register.
  ral_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_op                (in_ch.op),
    .in_index             (in_ch.index),
    .in_value             (in_ch.value),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_status           (out_ch.status),
    .out_found            (out_ch.found),
    .out_read_value       (out_ch.read_value),
    .out_element_count    (out_ch.element_count),
    .out_logical_capacity (out_ch.logical_capacity)
  );

endmodule

/* rtl/ral_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the resizable array list, bound to the top level.
// Depends on ral_pkg and resizable_array_list.
module ral_checker import ral_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [STAT_W-1:0]    out_status,
  input logic                 out_found,
  input logic [DATA_W-1:0]    out_read_value,
  input logic [OUT_CNT_W-1:0] out_element_count,
  input logic [OUT_CNT_W-1:0] out_logical_capacity
);

  // Requests accepted but not yet answered; at most two are in flight.
  logic [1:0] open_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else begin
      open_r <= open_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  // A result held back by the sink stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // Every result answers an earlier request.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> open_r != 2'd0)
    else $error("result without an open request");

  // The list never outgrows its capacity, which is never zero.
  a_sizes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_element_count <= out_logical_capacity) &&
                  (out_logical_capacity != '0))
    else $error("count exceeds capacity or capacity is zero");

  // A refused request reports no lookup data.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> !out_found && (out_read_value == '0))
    else $error("error result carries lookup data");

endmodule

bind resizable_array_list ral_checker u_ral_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_status           (out_ch.status),
  .out_found            (out_ch.found),
  .out_read_value       (out_ch.read_value),
  .out_element_count    (out_ch.element_count),
  .out_logical_capacity (out_ch.logical_capacity)
);
